>>> rtl/assert_macros.svh
// Assertion macros used by the allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define CABA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define CABA_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CABA_ASSERT(label, clk, rstn, prop, msg)
`define CABA_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

>>> rtl/caba_pkg.sv
// Shared types and constants of the chained arena bump allocator.
`default_nettype none
package caba_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int FAIL_LIMIT_DEF = 4;

    // Fixed field widths.
    localparam int SIZE_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int BIDX_W      = 4;
    localparam int FAIL_W      = 3;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;

    localparam logic [FAIL_W-1:0] FAIL_SAT     = 3'd7;
    localparam logic [SIZE_W-1:0] CAP_RESET    = 16'd4000;

    // Request kinds carried in s_tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // Result status codes carried in m_tuser.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_BLOCKS = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RESET     = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } ctrl_state_t;

    // Flags of the search token that walks the cell chain.
    typedef struct packed {
        logic valid;
        logic found;
    } tok_flags_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic clear;
        logic grow;
    } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/caba_cell.sv
// One block of the arena: its fill level, its failure counter and one token stage.
`default_nettype none
module caba_cell
    import caba_pkg::*;
#(
    parameter int FAIL_LIMIT = FAIL_LIMIT_DEF,
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  wire  logic              aclk,
    input  wire  logic              aresetn,
    input  wire  logic [SIZE_W-1:0] capacity,
    input  wire  logic [SIZE_W-1:0] size,
    input  wire  logic [IDX_W-1:0]  cur_block,
    input  wire  logic [CNT_W-1:0]  blocks_used,
    input  wire  cell_cmd_t         cmd,
    input  wire  tok_flags_t        tok_in,
    input  wire  logic [IDX_W-1:0]  tok_in_idx,
    input  wire  logic [SIZE_W-1:0] tok_in_off,
    input  wire  logic [IDX_W-1:0]  tok_in_nc,
    output tok_flags_t              tok_out,
    output logic       [IDX_W-1:0]  tok_out_idx,
    output logic       [SIZE_W-1:0] tok_out_off,
    output logic       [IDX_W-1:0]  tok_out_nc
);

    localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0]  MY_POS   = CNT_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0]  MY_NEXT  = CNT_W'(CELL_INDEX + 1);
    localparam logic [IDX_W-1:0]  MY_NC    = IDX_W'(CELL_INDEX + 1);
    localparam logic [FAIL_W-1:0] LIMIT    = FAIL_W'(FAIL_LIMIT);

    logic [SIZE_W-1:0] fill_reg, fill_next;
    logic [FAIL_W-1:0] fail_reg, fail_next;
    tok_flags_t        tok_reg, tok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SIZE_W-1:0] off_reg, off_next;
    logic [IDX_W-1:0]  nc_reg, nc_next;

    logic in_range;
    logic below_tail;
    logic is_new;
    logic fits;

    // Position of this block relative to the scanned span.
    assign in_range   = (MY_POS >= CNT_W'(cur_block)) && (MY_POS < blocks_used);
    assign below_tail = in_range && (MY_NEXT < blocks_used);
    assign is_new     = (MY_POS == blocks_used);

    // The first block in span with strictly more free space than the size takes it.
    assign fits = tok_in.valid && !tok_in.found && in_range &&
                  (fill_reg < capacity) && ((capacity - fill_reg) > size);

    // Token stage: take the allocation or pass the token on.
    always_comb begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found || fits;
        idx_next       = fits ? MY_IDX : tok_in_idx;
        off_next       = fits ? fill_reg : tok_in_off;
        if (tok_in.valid && below_tail && (fail_reg > LIMIT)) begin
            nc_next = MY_NC;
        end else begin
            nc_next = tok_in_nc;
        end
    end

    // Block state: bump, append, raise the counter or clear.
    always_comb begin
        fill_next = fill_reg;
        fail_next = fail_reg;
        if (cmd.clear) begin
            fill_next = '0;
            fail_next = '0;
        end else if (cmd.grow) begin
            if (is_new) begin
                fill_next = size;
                fail_next = '0;
            end else if (below_tail && (fail_reg < FAIL_SAT)) begin
                fail_next = fail_reg + 1'b1;
            end
        end else if (fits) begin
            fill_next = fill_reg + size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            fail_reg <= '0;
            tok_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            fail_reg <= fail_next;
            tok_reg  <= tok_next;
        end
    end

    // Token payload needs no reset.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        off_reg <= off_next;
        nc_reg  <= nc_next;
    end

    assign tok_out     = tok_reg;
    assign tok_out_idx = idx_reg;
    assign tok_out_off = off_reg;
    assign tok_out_nc  = nc_reg;

endmodule
`default_nettype wire

>>> rtl/caba_ctrl.sv
// Controller: request intake, pool counters, capacity register and result register.
`default_nettype none
`include "assert_macros.svh"
module caba_ctrl
    import caba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  wire  logic                 aclk,
    input  wire  logic                 aresetn,
    input  wire  logic                 s_tvalid,
    output logic                       s_tready,
    input  wire  logic [S_TDATA_W-1:0] s_tdata,
    input  wire  logic                 s_tuser,
    output logic                       m_tvalid,
    input  wire  logic                 m_tready,
    output logic       [M_TDATA_W-1:0] m_tdata,
    output logic       [M_TUSER_W-1:0] m_tuser,
    input  wire  logic                 cfg_we,
    input  wire  logic [SIZE_W-1:0]    cfg_wdata,
    output logic       [SIZE_W-1:0]    capacity,
    output logic       [SIZE_W-1:0]    size,
    output logic       [IDX_W-1:0]     cur_block,
    output logic       [CNT_W-1:0]     blocks_used,
    output cell_cmd_t                  cmd,
    output tok_flags_t                 launch,
    input  wire  tok_flags_t           tail,
    input  wire  logic [IDX_W-1:0]     tail_idx,
    input  wire  logic [SIZE_W-1:0]    tail_off,
    input  wire  logic [IDX_W-1:0]     tail_nc
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

    ctrl_state_t         state_reg, state_next;
    logic [SIZE_W-1:0]   cap_reg;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                launch_reg, launch_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [SIZE_W-1:0]   res_off_reg, res_off_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_load;
    logic [STATUS_W-1:0] m_status_reg;
    logic [BIDX_W-1:0]   m_idx_reg;
    logic [SIZE_W-1:0]   m_off_reg;
    logic [IDX_W+BIDX_W-1:0] res_idx_ext;
    logic                accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state, pool counters and the pending result.
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        size_next       = size_reg;
        launch_next     = 1'b0;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_off_next    = res_off_reg;
        cmd             = '0;
        m_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_idx_next = '0;
                    res_off_next = '0;
                    if (s_tuser == OP_RESET) begin
                        cmd.clear       = 1'b1;
                        cur_next        = '0;
                        res_status_next = STATUS_RESET;
                        state_next      = ST_OUT;
                    end else if (s_tdata >= cap_reg) begin
                        res_status_next = STATUS_TOO_LARGE;
                        state_next      = ST_OUT;
                    end else begin
                        size_next   = s_tdata;
                        launch_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tail.valid) begin
                    state_next = ST_OUT;
                    if (tail.found) begin
                        res_status_next = STATUS_OK;
                        res_idx_next    = tail_idx;
                        res_off_next    = tail_off;
                    end else if (used_reg == MAX_CNT) begin
                        res_status_next = STATUS_NO_BLOCKS;
                        res_idx_next    = '0;
                        res_off_next    = '0;
                    end else begin
                        // Append a block; the cells raise counters in the same cycle.
                        cmd.grow        = 1'b1;
                        cur_next        = tail_nc;
                        used_next       = used_reg + 1'b1;
                        res_status_next = STATUS_OK;
                        res_idx_next    = used_reg[IDX_W-1:0];
                        res_off_next    = '0;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = m_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            used_reg    <= CNT_W'(1);
            cur_reg     <= '0;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cur_reg     <= cur_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Block number on the bus is its low four bits.
    assign res_idx_ext = {{BIDX_W{1'b0}}, res_idx_reg};

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_off_reg    <= res_off_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_idx_reg    <= res_idx_ext[BIDX_W-1:0];
            m_off_reg    <= res_off_reg;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_tuser      = m_status_reg;
    assign m_tdata      = {{(M_TDATA_W - SIZE_W - BIDX_W){1'b0}}, m_off_reg, m_idx_reg};
    assign capacity     = cap_reg;
    assign size         = size_reg;
    assign cur_block    = cur_reg;
    assign blocks_used  = used_reg;
    assign launch.valid = launch_reg;
    assign launch.found = 1'b0;

    // The chain always holds at least one block and never more than it has cells.
    `CABA_ASSERT(a_used_range, aclk, aresetn, (used_reg != '0) && (used_reg <= MAX_CNT), "blocks in use out of range")
    // The current block lies inside the chain.
    `CABA_ASSERT(a_cur_in_chain, aclk, aresetn, CNT_W'(cur_reg) < used_reg, "current block beyond tail")
    // A token only leaves the chain while the controller waits for it.
    `CABA_ASSERT(a_tail_in_scan, aclk, aresetn, tail.valid |-> (state_reg == ST_SCAN), "token outside scan")
    // A search is launched at most once per allocation request.
    `CABA_ASSERT(a_single_launch, aclk, aresetn, launch_reg |=> !launch_reg, "token launched twice")
    // Appending a block never happens at a full chain.
    `CABA_NEVER(a_grow_full, aclk, aresetn, cmd.grow && (used_reg == MAX_CNT), "append on full chain")

endmodule
`default_nettype wire

>>> rtl/chained_arena_bump_allocator_top.sv
// Chained arena bump allocator: controller and the chain of block cells.
//
// Requests arrive on the s_ stream: s_tuser selects allocate (0) or pool
// reset (1), s_tdata carries the size in bytes. Each request yields one word
// on the m_ stream: m_tuser is the status, m_tdata the block and offset.
// cfg_we/cfg_wdata write the block capacity; write it only while idle.
// An allocation walks a token through one cell per block, one cell per
// clock; its result then passes the result register and the output
// register. Too-large and pool-reset requests are written straight to the
// result register and move on to the output register. One request is
// in work at a time; the next one is accepted in the cycle after the
// previous result has moved into the output register, even if the receiver
// has not taken it yet.
// When m_tready is low the result word holds and the block stops taking
// requests once its pending result cannot move on.
// After aresetn all blocks are empty, counters are clear, one block is in
// use and the capacity is 4000 bytes.
`default_nettype none
module chained_arena_bump_allocator_top
    import caba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int FAIL_LIMIT = FAIL_LIMIT_DEF
) (
    input  wire  logic                 aclk,
    input  wire  logic                 aresetn,
    input  wire  logic                 s_tvalid,
    output logic                       s_tready,
    input  wire  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] alloc_size
    input  wire  logic                 s_tuser,   // [0] op
    output logic                       m_tvalid,
    input  wire  logic                 m_tready,
    output logic       [M_TDATA_W-1:0] m_tdata,   // [3:0] block_index, [19:4] offset, zero pad
    output logic       [M_TUSER_W-1:0] m_tuser,   // [1:0] status
    input  wire  logic                 cfg_we,
    input  wire  logic [SIZE_W-1:0]    cfg_wdata
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [SIZE_W-1:0] capacity;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  cur_block;
    logic [CNT_W-1:0]  blocks_used;
    cell_cmd_t         cmd;

    // Token links between neighboring cells; link 0 comes from the controller.
    tok_flags_t        tok     [0:MAX_BLOCKS];
    logic [IDX_W-1:0]  tok_idx [0:MAX_BLOCKS];
    logic [SIZE_W-1:0] tok_off [0:MAX_BLOCKS];
    logic [IDX_W-1:0]  tok_nc  [0:MAX_BLOCKS];

    assign tok_idx[0] = '0;
    assign tok_off[0] = '0;
    assign tok_nc[0]  = cur_block;

    caba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .capacity    (capacity),
        .size        (size),
        .cur_block   (cur_block),
        .blocks_used (blocks_used),
        .cmd         (cmd),
        .launch      (tok[0]),
        .tail        (tok[MAX_BLOCKS]),
        .tail_idx    (tok_idx[MAX_BLOCKS]),
        .tail_off    (tok_off[MAX_BLOCKS]),
        .tail_nc     (tok_nc[MAX_BLOCKS])
    );

    // One cell per block, chained in block order.
    for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
        caba_cell #(
            .FAIL_LIMIT (FAIL_LIMIT),
            .CELL_INDEX (i),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .capacity    (capacity),
            .size        (size),
            .cur_block   (cur_block),
            .blocks_used (blocks_used),
            .cmd         (cmd),
            .tok_in      (tok[i]),
            .tok_in_idx  (tok_idx[i]),
            .tok_in_off  (tok_off[i]),
            .tok_in_nc   (tok_nc[i]),
            .tok_out     (tok[i+1]),
            .tok_out_idx (tok_idx[i+1]),
            .tok_out_off (tok_off[i+1]),
            .tok_out_nc  (tok_nc[i+1])
        );
    end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench of the chained arena bump allocator.
`default_nettype none
module testbench;
    import caba_pkg::*;

    localparam int NUM_BLOCKS    = MAX_BLOCKS_DEF;
    localparam int PHASE_ITEMS   = 194;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 300;
    localparam int IDLE_PCT      = 8;
    localparam int QUIET_FIRST   = 700;
    localparam int QUIET_LAST    = 900;
    localparam int DRAIN_AT      = 1100;
    localparam int SETTLE_CYCLES = 40;

    // One result word as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIDX_W-1:0]   blk;
        logic [SIZE_W-1:0]   off;
    } alloc_result_t;

    // One row of the directed table: a request, how often it repeats, and
    // optionally the result that is obvious from the request alone.
    typedef struct packed {
        logic          op;
        logic [15:0]   size;
        logic [4:0]    reps;
        logic          typed;
        alloc_result_t want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // [15:0] alloc_size
    logic                 s_tuser;    // [0] op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // [3:0] block_index, [19:4] offset, zero pad
    logic [M_TUSER_W-1:0] m_tuser;    // [1:0] status
    logic                 cfg_we;
    logic [SIZE_W-1:0]    cfg_wdata;

    // Shadow copy of the pool state, kept by the predictor.
    logic [SIZE_W-1:0] pool_fill [NUM_BLOCKS];
    logic [FAIL_W-1:0] pool_fails [NUM_BLOCKS];
    logic [4:0]        pool_blocks;
    logic [BIDX_W-1:0] pool_cursor;
    logic [SIZE_W-1:0] pool_capacity;

    alloc_result_t pending_results [$];
    alloc_result_t oldest_result;
    stim_row_t     directed_rows [12];
    int            results_seen;
    int            mismatch_total;
    int            items_sent;
    logic          quiet_stretch;
    logic          hold_done;

    chained_arena_bump_allocator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock with a period of two time units.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Applies one request to the shadow pool and returns its result word.
    function automatic alloc_result_t predict_alloc(input logic op, input logic [15:0] size);
        alloc_result_t r;
        int            b;
        int            used;
        int            next_cursor;
        logic [FAIL_W-1:0] f;
        r = '{STATUS_OK, '0, '0};
        if (op == OP_RESET) begin
            for (b = 0; b < NUM_BLOCKS; b++) begin
                pool_fill[b]  = '0;
                pool_fails[b] = '0;
            end
            pool_cursor = '0;
            r.status = STATUS_RESET;
            return r;
        end
        if (size >= pool_capacity) begin
            r.status = STATUS_TOO_LARGE;
            return r;
        end
        used = pool_blocks;
        // First block from the cursor on with strictly more room than asked.
        for (b = pool_cursor; b < used; b++) begin
            if (pool_fill[b] < pool_capacity && pool_capacity - pool_fill[b] > size) begin
                r.blk = b[BIDX_W-1:0];
                r.off = pool_fill[b];
                pool_fill[b] = pool_fill[b] + size;
                return r;
            end
        end
        if (used >= NUM_BLOCKS) begin
            r.status = STATUS_NO_BLOCKS;
            return r;
        end
        // Charge a miss to every block before the old tail and skip the
        // ones that had already missed too often.
        next_cursor = pool_cursor;
        for (b = pool_cursor; b < used - 1; b++) begin
            f = pool_fails[b];
            if (f != FAIL_SAT) begin
                pool_fails[b] = f + 1'b1;
            end
            if (f > FAIL_LIMIT_DEF) begin
                next_cursor = b + 1;
            end
        end
        pool_cursor = next_cursor[BIDX_W-1:0];
        pool_fill[used]  = size;
        pool_fails[used] = '0;
        pool_blocks = 5'(used + 1);
        r.blk = used[BIDX_W-1:0];
        return r;
    endfunction

    // Random request size, weighted toward sizes that fit the capacity.
    function automatic logic [15:0] pick_size();
        int sel;
        int top;
        sel = $urandom_range(9);
        top = pool_capacity;
        case (sel)
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'(top - 1);
            3: return 16'(top);
            4: return 16'($urandom_range(top - 1, 0));
            default: return 16'($urandom_range(top / 4, 0));
        endcase
    endfunction

    // Offers one request word, with random gaps, and records its result.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_request(input logic op, input logic [15:0] size,
                                 input logic typed, input alloc_result_t want);
        alloc_result_t got;
        while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= size;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        got = predict_alloc(op, size);
        pending_results.push_back(typed ? want : got);
        items_sent++;
        quiet_stretch = (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every outstanding result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Writes the block capacity; the block must be idle.
    task automatic set_capacity(input logic [SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        pool_capacity = value;
    endtask

    // Result checker: every accepted word is compared with the oldest
    // expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, status %0d block %0d offset %0d",
                         $time, m_tuser, m_tdata[3:0], m_tdata[19:4]);
                mismatch_total++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_tuser !== oldest_result.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, oldest_result.status, m_tuser);
                    mismatch_total++;
                end
                if (m_tdata[3:0] !== oldest_result.blk) begin
                    $display("%0t: block_index mismatch, expected %0d, got %0d",
                             $time, oldest_result.blk, m_tdata[3:0]);
                    mismatch_total++;
                end
                if (m_tdata[19:4] !== oldest_result.off) begin
                    $display("%0t: offset mismatch, expected %0d, got %0d",
                             $time, oldest_result.off, m_tdata[19:4]);
                    mismatch_total++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off so the block backs up.
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #800000;
        $display("testbench NOT OK");
        $finish;
    end

    // Reset, directed table, then random phases under several capacities.
    initial begin
        int           row;
        int           rep;
        int           phase;
        int           n;
        int           phase_caps [8];
        logic [15:0]  cap;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_ALLOC;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        results_seen   = 0;
        mismatch_total = 0;
        items_sent     = 0;
        quiet_stretch  = 1'b0;

        for (n = 0; n < NUM_BLOCKS; n++) begin
            pool_fill[n]  = '0;
            pool_fails[n] = '0;
        end
        pool_blocks   = 5'd1;
        pool_cursor   = '0;
        pool_capacity = CAP_RESET;

        // Capacity 4000 after reset. The long row of near-full requests
        // appends a block each time until the pool is exhausted, which also
        // walks the cursor past the blocks that keep missing.
        directed_rows = '{
            '{OP_ALLOC, 16'd0,     5'd1,  1'b1, '{STATUS_OK,        4'd0, 16'd0}},
            '{OP_ALLOC, 16'd65535, 5'd1,  1'b1, '{STATUS_TOO_LARGE, 4'd0, 16'd0}},
            '{OP_ALLOC, 16'd4000,  5'd1,  1'b1, '{STATUS_TOO_LARGE, 4'd0, 16'd0}},
            '{OP_ALLOC, 16'd3999,  5'd1,  1'b1, '{STATUS_OK,        4'd0, 16'd0}},
            '{OP_ALLOC, 16'd0,     5'd1,  1'b1, '{STATUS_OK,        4'd0, 16'd3999}},
            '{OP_ALLOC, 16'd1,     5'd1,  1'b1, '{STATUS_OK,        4'd1, 16'd0}},
            '{OP_ALLOC, 16'd3999,  5'd14, 1'b0, '{STATUS_OK,        4'd0, 16'd0}},
            '{OP_ALLOC, 16'd3999,  5'd1,  1'b1, '{STATUS_NO_BLOCKS, 4'd0, 16'd0}},
            '{OP_ALLOC, 16'd3998,  5'd1,  1'b0, '{STATUS_OK,        4'd0, 16'd0}},
            '{OP_RESET, 16'd65535, 5'd1,  1'b1, '{STATUS_RESET,     4'd0, 16'd0}},
            '{OP_ALLOC, 16'd3999,  5'd1,  1'b1, '{STATUS_OK,        4'd0, 16'd0}},
            '{OP_ALLOC, 16'd1,     5'd1,  1'b1, '{STATUS_OK,        4'd1, 16'd0}}
        };
        // A zero entry picks a random capacity; the 300 phase follows a
        // 1 phase and a 65535 phase, so leftover fills overrun it.
        phase_caps = '{4000, 65535, 1, 300, 0, 9, 0, 65535};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (row = 0; row < 12; row++) begin
            for (rep = 0; rep < directed_rows[row].reps; rep++) begin
                offer_request(directed_rows[row].op, directed_rows[row].size,
                              directed_rows[row].typed, directed_rows[row].want);
            end
        end

        for (phase = 0; phase < 8; phase++) begin
            wait_drained();
            cap = (phase_caps[phase] == 0) ? 16'($urandom_range(65534, 2))
                                           : 16'(phase_caps[phase]);
            set_capacity(cap);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (items_sent == DRAIN_AT) begin
                    wait_drained();
                end
                if ($urandom_range(24) == 0) begin
                    offer_request(OP_RESET, 16'($urandom), 1'b0, '0);
                end else begin
                    offer_request(OP_ALLOC, pick_size(), 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending_results.size());
            mismatch_total++;
        end
        if (mismatch_total == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
